[rtl/rsas_pkg.sv]
// shared types, codes and the control program for the rotated sorted array search
// no dependencies
package rsas_pkg;

	localparam int DEPTH_DEF = 1024;
	localparam int VALUE_W   = 32;
	localparam int ACTION_W  = 2;
	localparam int INDEX_W   = 10;

	typedef enum logic [ACTION_W-1:0] {
		ACT_APPEND = 2'd0,
		ACT_SEARCH = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	// program addresses
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK,
		ST_PIV_RD,
		ST_PIV_UPD,
		ST_SEL_RD,
		ST_SEL_UPD,
		ST_BS_RD,
		ST_BS_UPD,
		ST_DONE
	} step_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_PIV_RD,
		OP_PIV_UPD,
		OP_SEL_RD,
		OP_SEL_UPD,
		OP_BS_RD,
		OP_BS_UPD,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_SEARCH,
		C_EMPTY,
		C_LO_GE_HI,
		C_LO_GT_HI,
		C_MISS,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
		logic  ret;
	} ctrl_t;

	typedef struct packed {
		logic search_acc;
		logic empty;
		logic lo_ge_hi;
		logic lo_gt_hi;
		logic miss;
		logic out_busy;
	} stat_t;

	// control store: jump to target when cond holds, else next step (or step 0 on ret)
	function automatic ctrl_t rsas_rom(step_t step);
		ctrl_t w;
		unique case (step)
			ST_IDLE:    w = '{op: OP_ACCEPT,  cond: C_NO_SEARCH, target: ST_IDLE,   ret: 1'b0};
			ST_CHK:     w = '{op: OP_NOP,     cond: C_EMPTY,     target: ST_DONE,   ret: 1'b0};
			ST_PIV_RD:  w = '{op: OP_PIV_RD,  cond: C_LO_GE_HI,  target: ST_SEL_RD, ret: 1'b0};
			ST_PIV_UPD: w = '{op: OP_PIV_UPD, cond: C_ALWAYS,    target: ST_PIV_RD, ret: 1'b0};
			ST_SEL_RD:  w = '{op: OP_SEL_RD,  cond: C_NEVER,     target: ST_IDLE,   ret: 1'b0};
			ST_SEL_UPD: w = '{op: OP_SEL_UPD, cond: C_NEVER,     target: ST_IDLE,   ret: 1'b0};
			ST_BS_RD:   w = '{op: OP_BS_RD,   cond: C_LO_GT_HI,  target: ST_DONE,   ret: 1'b0};
			ST_BS_UPD:  w = '{op: OP_BS_UPD,  cond: C_MISS,      target: ST_BS_RD,  ret: 1'b0};
			ST_DONE:    w = '{op: OP_EMIT,    cond: C_OUT_BUSY,  target: ST_DONE,   ret: 1'b1};
			default:    w = '{op: OP_NOP,     cond: C_NEVER,     target: ST_IDLE,   ret: 1'b1};
		endcase
		return w;
	endfunction

endpackage

[rtl/rsas_ram.sv]
// generic ram: one write port, two registered read ports
// no dependencies
module rsas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

[rtl/rsas_seq.sv]
// microcode sequencer: step counter, control store and jump logic
// depends on rsas_pkg
module rsas_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  rsas_pkg::stat_t stat,
	output rsas_pkg::ctrl_t ctrl
);
	import rsas_pkg::*;

	step_t pc_q;
	step_t pc_d;
	logic  take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_comb begin
		ctrl = rsas_rom(pc_q);
		unique case (ctrl.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_SEARCH: take = !stat.search_acc;
			C_EMPTY:     take = stat.empty;
			C_LO_GE_HI:  take = stat.lo_ge_hi;
			C_LO_GT_HI:  take = stat.lo_gt_hi;
			C_MISS:      take = stat.miss;
			C_OUT_BUSY:  take = stat.out_busy;
			default:     take = 1'b0;
		endcase
		priority if (take) begin
			pc_d = ctrl.target;
		end else if (ctrl.ret) begin
			pc_d = ST_IDLE;
		end else begin
			pc_d = step_t'(pc_q + 4'd1);
		end
	end

	// the program only steps into its own addresses
	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= ST_DONE) else $error("sequencer left the program");

	// a search always leaves the idle step
	a_search_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == ST_IDLE && stat.search_acc) |=> pc_q == ST_CHK)
		else $error("search transfer not dispatched");

	// the result step is left only when the output register takes the result
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == ST_DONE && stat.out_busy) |=> pc_q == ST_DONE)
		else $error("result step left while output busy");

endmodule

[rtl/rsas_dp.sv]
// datapath: element count, search bounds, element memory and output register
// depends on rsas_pkg, rsas_ram
module rsas_dp #(
	parameter int DEPTH = rsas_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rsas_pkg::ctrl_t                    ctrl,
	output rsas_pkg::stat_t                    stat,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [rsas_pkg::VALUE_W-1:0]       s_tdata,
	input  logic [rsas_pkg::ACTION_W-1:0]      s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [rsas_pkg::INDEX_W-1:0]       m_tdata,
	output logic                               m_tuser
);
	import rsas_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = AW + 2;
	localparam logic signed [PW-1:0] ONE   = PW'(1);
	localparam logic [CW-1:0]        FULL  = CW'(DEPTH);

	logic [CW-1:0]              count_q;
	logic signed [PW-1:0]       lo_q, hi_q;
	logic [AW-1:0]              mid_q, pivot_q;
	logic signed [VALUE_W-1:0]  target_q;
	logic                       hit_q;
	logic [INDEX_W-1:0]         hit_idx_q;
	logic                       out_valid_q, out_found_q;
	logic [INDEX_W-1:0]         out_idx_q;

	logic                       acc;
	logic                       we;
	logic signed [PW-1:0]       sum, n_m1;
	logic [AW-1:0]              mid_w, raddr_a, raddr_b;
	logic [VALUE_W-1:0]         rdata_a, rdata_b;
	logic signed [VALUE_W-1:0]  rd_a, rd_b;
	logic                       emit;

	assign s_tready = (ctrl.op == OP_ACCEPT);
	assign acc      = s_tready && s_tvalid;
	assign we       = acc && (s_tuser == ACT_APPEND) && (count_q != FULL);
	assign sum      = lo_q + hi_q;
	assign mid_w    = sum[AW:1];
	assign n_m1     = $signed(PW'(count_q)) - ONE;
	assign rd_a     = $signed(rdata_a);
	assign rd_b     = $signed(rdata_b);
	assign emit     = (ctrl.op == OP_EMIT) && !stat.out_busy;

	always_comb begin
		stat.search_acc = acc && (s_tuser == ACT_SEARCH);
		stat.empty      = (count_q == '0);
		stat.lo_ge_hi   = (lo_q >= hi_q);
		stat.lo_gt_hi   = (lo_q > hi_q);
		stat.miss       = (rd_a != target_q);
		stat.out_busy   = out_valid_q && !m_tready;
	end

	// port a probes the middle (or the pivot), port b the upper bound (or the last entry)
	always_comb begin
		unique case (ctrl.op)
			OP_SEL_RD: begin
				raddr_a = lo_q[AW-1:0];
				raddr_b = n_m1[AW-1:0];
			end
			default: begin
				raddr_a = mid_w;
				raddr_b = hi_q[AW-1:0];
			end
		endcase
	end

	rsas_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (count_q[AW-1:0]),
		.wdata  (s_tdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (acc) begin
			if (we) begin
				count_q <= count_q + CW'(1);
			end else if (s_tuser == ACT_CLEAR) begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_ACCEPT: begin
				if (stat.search_acc) begin
					target_q  <= $signed(s_tdata);
					lo_q      <= '0;
					hi_q      <= n_m1;
					hit_q     <= 1'b0;
					hit_idx_q <= '0;
				end
			end
			OP_PIV_RD, OP_BS_RD: begin
				mid_q <= mid_w;
			end
			OP_PIV_UPD: begin
				if (rd_a > rd_b) begin
					lo_q <= $signed(PW'(mid_q)) + ONE;
				end else begin
					hi_q <= $signed(PW'(mid_q));
				end
			end
			OP_SEL_RD: begin
				pivot_q <= lo_q[AW-1:0];
			end
			OP_SEL_UPD: begin
				// target above both the last entry and the minimum: left half
				if (target_q > rd_b && target_q > rd_a) begin
					lo_q <= '0;
					hi_q <= $signed(PW'(pivot_q)) - ONE;
				end else begin
					lo_q <= $signed(PW'(pivot_q));
					hi_q <= n_m1;
				end
			end
			OP_BS_UPD: begin
				if (rd_a == target_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= INDEX_W'(mid_q);
				end else if (rd_a > target_q) begin
					hi_q <= $signed(PW'(mid_q)) - ONE;
				end else begin
					lo_q <= $signed(PW'(mid_q)) + ONE;
				end
			end
			default: begin
			end
		endcase
	end

	// output register, loads while empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_found_q <= hit_q;
			out_idx_q   <= hit_idx_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = out_idx_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL) else $error("element count beyond capacity");

	a_pivot_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_PIV_UPD) |-> (lo_q < hi_q && lo_q >= 0))
		else $error("pivot probe outside bounds");

	a_bs_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_BS_UPD) |-> (lo_q <= hi_q && lo_q >= 0 && hi_q < $signed(PW'(count_q))))
		else $error("search probe outside stored entries");

	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_found_q) |-> (out_idx_q == '0))
		else $error("not-found result with nonzero index");

endmodule

[rtl/rotated_sorted_array_search_top.sv]
// append/clear/search on a rotated ascending array: a search runs a binary search for the
// pivot, then one for the target, each probe waiting on the registered memory read;
// one search in flight at a time
// reset clears the element count and the sequencer; memory contents stay undefined
// depends on rsas_pkg, rsas_seq, rsas_dp, rsas_ram
module rotated_sorted_array_search_top #(
	parameter int DEPTH = rsas_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rsas_pkg::VALUE_W-1:0]  s_tdata,   // [31:0] value
	input  logic [rsas_pkg::ACTION_W-1:0] s_tuser,   // [1:0] action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,   // [9:0] index, [15:10] zero
	output logic                          m_tuser    // [0] found
);
	import rsas_pkg::*;

	ctrl_t              ctrl;
	stat_t              stat;
	logic [INDEX_W-1:0] idx;

	rsas_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.ctrl  (ctrl)
	);

	rsas_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.stat    (stat),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (idx),
		.m_tuser (m_tuser)
	);

	assign m_tdata = 16'(idx);

endmodule
